/* sv/srb_pkg.sv */
// Shared types and codes for the sequence reorder buffer.
// No dependencies; imported by srb_ctrl, srb_dp and the top level.
package srb_pkg;

  // result status codes
  localparam logic [1:0] STATUS_RELEASED = 2'd0;
  localparam logic [1:0] STATUS_LATE     = 2'd1;
  localparam logic [1:0] STATUS_BEYOND   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_OUT  = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;    // request accepted this cycle
    logic read_slot;  // fetch payload of the head slot
    logic load_slot;  // present the fetched slot as the next result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;       // incoming request produces a result (not parked)
    logic out_last;   // result held in the output register ends the run
  } status_t;

endpackage

/* sv/srb_ctrl.sv */
// Controller FSM for the sequence reorder buffer.
// Depends on srb_pkg; drives the handshakes and commands srb_dp.
module srb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  srb_pkg::status_t status,
  output srb_pkg::cmd_t    cmd
);
  import srb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    cmd.take_in   = (state_r == ST_IDLE) && in_valid;
    cmd.read_slot = out_take && !status.out_last;
    cmd.load_slot = (state_r == ST_LOAD);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.emit) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_take) state_nxt = status.out_last ? ST_IDLE : ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !status.out_last |=> (state_r == ST_LOAD) ##1 out_valid)
    else $error("drain run did not continue");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && status.out_last |=> !in_stall)
    else $error("not ready after last result");

endmodule

/* sv/srb_dp.sv */
// Datapath of the sequence reorder buffer: window check, slot store,
// expected id / head tracking and the output register. Depends on srb_pkg.
module srb_dp #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic [31:0]      in_frame_id,
  input  logic [31:0]      in_frame_payload,
  input  srb_pkg::cmd_t    cmd,
  output srb_pkg::status_t status,
  output logic [31:0]      out_id,
  output logic [31:0]      out_payload,
  output logic [1:0]       out_result_status,
  output logic             out_last_of_run
);
  import srb_pkg::*;

  localparam int HW = $clog2(WINDOW_DEPTH);
  localparam logic [HW-1:0] LAST_SLOT = HW'(WINDOW_DEPTH - 1);
  localparam logic [HW:0]   DEPTH_EXT = (HW+1)'(WINDOW_DEPTH);

  logic [31:0]             expected_r;
  logic [HW-1:0]           head_r;
  logic [WINDOW_DEPTH-1:0] slot_valid_r;
  logic [31:0]             slot_mem [WINDOW_DEPTH];
  logic [31:0]             rd_data_r;
  logic [31:0]             out_id_r, out_payload_r;
  logic [1:0]              out_status_r;
  logic                    out_last_r;

  logic [31:0]   seq_delta;
  logic          in_order, late, beyond, dup;
  logic [HW:0]   slot_sum;
  logic [HW-1:0] slot_idx, head_inc;

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  // slot = (head + d) mod depth, d < depth here
  always_comb begin
    seq_delta = in_frame_id - expected_r;
    in_order  = (seq_delta == 32'd0);
    late      = seq_delta[31];
    beyond    = !seq_delta[31] && (seq_delta >= 32'(WINDOW_DEPTH));
    slot_sum  = {1'b0, head_r} + {1'b0, seq_delta[HW-1:0]};
    if (slot_sum >= DEPTH_EXT) slot_sum = slot_sum - DEPTH_EXT;
    slot_idx  = slot_sum[HW-1:0];
    dup       = slot_valid_r[slot_idx];
  end

  assign status.emit     = in_order || late || beyond || dup;
  assign status.out_last = out_last_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= '0;
      head_r       <= '0;
      slot_valid_r <= '0;
    end else if (cfg_wr_en) begin
      // restart: head origin is arbitrary once all slots are empty
      expected_r   <= cfg_wr_data;
      head_r       <= '0;
      slot_valid_r <= '0;
    end else if (cmd.take_in) begin
      if (in_order) begin
        expected_r <= expected_r + 32'd1;
        head_r     <= head_inc;
      end else if (!status.emit) begin
        slot_valid_r[slot_idx] <= 1'b1;
      end
    end else if (cmd.load_slot) begin
      slot_valid_r[head_r] <= 1'b0;
      expected_r           <= expected_r + 32'd1;
      head_r               <= head_inc;
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (cmd.take_in && !status.emit) slot_mem[slot_idx] <= in_frame_payload;
    if (cmd.read_slot) rd_data_r <= slot_mem[head_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.take_in && status.emit) begin
      out_id_r      <= in_frame_id;
      out_payload_r <= in_frame_payload;
      if (in_order) begin
        out_status_r <= STATUS_RELEASED;
        out_last_r   <= !slot_valid_r[head_inc];
      end else begin
        out_status_r <= (beyond) ? STATUS_BEYOND : STATUS_LATE;
        out_last_r   <= 1'b1;
      end
    end else if (cmd.load_slot) begin
      out_id_r      <= expected_r;
      out_payload_r <= rd_data_r;
      out_status_r  <= STATUS_RELEASED;
      out_last_r    <= !slot_valid_r[head_inc];
    end
  end

  assign out_id            = out_id_r;
  assign out_payload       = out_payload_r;
  assign out_result_status = out_status_r;
  assign out_last_of_run   = out_last_r;

  a_drain_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_slot |-> slot_valid_r[head_r])
    else $error("draining an empty slot");

  a_release_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_in && in_order && !cfg_wr_en |=> expected_r == $past(expected_r) + 32'd1)
    else $error("expected id did not advance on release");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> slot_valid_r == '0)
    else $error("restart left slots occupied");

  a_park_off_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_in && !status.emit |-> slot_idx != head_r)
    else $error("frame parked in the slot of expected id");

endmodule

/* sv/sequence_reorder_buffer_core.sv */
// Sequence reorder buffer: accepts frames tagged with a sequence number in any
// order and releases them in sequence order. The in_ channel carries frame id
// and payload handle; the out_ channel carries id, payload, status and a
// last-of-run flag. Both use valid/stall; a request moves when valid is high
// and stall is low. cfg_wr_en/cfg_wr_data write the start sequence and restart
// the block (expected id set, all parked slots emptied); write only when idle.
// A frame equal to the expected id comes out in the cycle after acceptance and
// is followed by every consecutive parked frame, each by a slot read, then an
// output load; a receiver stall holds the run. A frame ahead within
// WINDOW_DEPTH-1 numbers is parked with no result and in_stall stays low.
// Late, duplicate and beyond-window frames give one error result.
// One frame is in work at a time: in_stall stays high from acceptance of a
// frame that produces results until its last result is taken. A stalled
// result holds on the output register. Reset clears the parked slots and sets
// the expected id to zero.
// Depends on srb_pkg, srb_ctrl and srb_dp.
module sequence_reorder_buffer_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_frame_id,
  input  logic [31:0] in_frame_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_id,
  output logic [31:0] out_payload,
  output logic [1:0]  out_result_status,
  output logic        out_last_of_run
);
  import srb_pkg::*;

  cmd_t    cmd;
  status_t status;

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  srb_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_frame_id       (in_frame_id),
    .in_frame_payload  (in_frame_payload),
    .cmd               (cmd),
    .status            (status),
    .out_id            (out_id),
    .out_payload       (out_payload),
    .out_result_status (out_result_status),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

/* test/srb_release_checker.sv */
// Scoreboard for the sequence reorder buffer: predicts the in-order release
// stream from accepted requests and compares every taken result.
// Depends on srb_pkg for the result status codes.
module srb_release_checker #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_frame_id,
  input  logic [31:0] in_frame_payload,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_id,
  input  logic [31:0] out_payload,
  input  logic [1:0]  out_result_status,
  input  logic        out_last_of_run,
  output int          frames_due,
  output int          mismatches
);
  import srb_pkg::*;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] payload;
    logic [1:0]  status;
    logic        last;
  } release_t;

  release_t    release_q[$];
  logic [31:0] next_release_id;
  int          head_slot;
  logic [31:0] parked_payload[WINDOW_DEPTH];
  logic        parked_valid[WINDOW_DEPTH];

  initial begin
    mismatches = 0;
    frames_due = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic restart_window(input logic [31:0] first);
    next_release_id = first;
    head_slot = first % WINDOW_DEPTH;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      parked_valid[i] = 1'b0;
    end
  endtask

  task automatic advance_head();
    next_release_id = next_release_id + 32'd1;
    head_slot = (head_slot + 1) % WINDOW_DEPTH;
  endtask

  task automatic queue_release(input logic [31:0] id, input logic [31:0] payload,
                               input logic [1:0] status, input logic last);
    release_t r;
    r.id = id;
    r.payload = payload;
    r.status = status;
    r.last = last;
    release_q.push_back(r);
  endtask

  task automatic predict_frame(input logic [31:0] id, input logic [31:0] payload);
    logic [31:0] ahead;
    logic [31:0] run_id;
    int          slot;
    ahead = id - next_release_id;
    if (ahead == 32'd0) begin
      advance_head();
      queue_release(id, payload, STATUS_RELEASED, !parked_valid[head_slot]);
      // drain the parked run behind the in-order frame
      while (parked_valid[head_slot]) begin
        slot = head_slot;
        run_id = next_release_id;
        parked_valid[slot] = 1'b0;
        advance_head();
        queue_release(run_id, parked_payload[slot], STATUS_RELEASED,
                      !parked_valid[head_slot]);
      end
    end else if (ahead[31]) begin
      queue_release(id, payload, STATUS_LATE, 1'b1);
    end else if (ahead >= WINDOW_DEPTH) begin
      queue_release(id, payload, STATUS_BEYOND, 1'b1);
    end else begin
      slot = (head_slot + int'(ahead)) % WINDOW_DEPTH;
      if (parked_valid[slot]) begin
        queue_release(id, payload, STATUS_LATE, 1'b1);
      end else begin
        parked_payload[slot] = payload;
        parked_valid[slot] = 1'b1;
      end
    end
  endtask

  task automatic check_release();
    release_t want;
    if (release_q.size() == 0) begin
      report($sformatf("result id=%h payload=%h with nothing pending", out_id, out_payload));
    end else begin
      want = release_q[0];
      release_q.delete(0);
      if (out_id !== want.id)
        report($sformatf("id %h, expected %h", out_id, want.id));
      if (out_payload !== want.payload)
        report($sformatf("payload %h, expected %h (id %h)", out_payload, want.payload,
                         want.id));
      if (out_result_status !== want.status)
        report($sformatf("status %0d, expected %0d (id %h)", out_result_status,
                         want.status, want.id));
      if (out_last_of_run !== want.last)
        report($sformatf("last_of_run %b, expected %b (id %h)", out_last_of_run,
                         want.last, want.id));
    end
  endtask

  // results leave in the cycle after acceptance at the earliest, so the taken
  // result is checked before the newly accepted request is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_window(32'd0);
      release_q.delete();
    end else begin
      if (out_valid && !out_stall) check_release();
      if (cfg_wr_en) restart_window(cfg_wr_data);
      if (in_valid && !in_stall) predict_frame(in_frame_id, in_frame_payload);
    end
    frames_due <= release_q.size();
  end

endmodule

/* test/sequence_reorder_buffer_core_test.sv */
// Testbench top for sequence_reorder_buffer_core: clock, reset, stimulus and
// receiver stalls. Checking is done by srb_release_checker (depends on srb_pkg).
module sequence_reorder_buffer_core_test;

  localparam int WINDOW_DEPTH = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 146;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_frame_id;
  logic [31:0] in_frame_payload;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_id;
  logic [31:0] out_payload;
  logic [1:0]  out_result_status;
  logic        out_last_of_run;

  int          frames_due;
  int          mismatches;
  int          frames_sent;
  int          cycle_count;
  int          in_idle_pct;
  int          out_idle_pct;
  logic        hold_off;
  logic        hold_go;
  logic [31:0] cursor;

  sequence_reorder_buffer_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_id      (in_frame_id),
    .in_frame_payload (in_frame_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_id           (out_id),
    .out_payload      (out_payload),
    .out_result_status(out_result_status),
    .out_last_of_run  (out_last_of_run)
  );

  srb_release_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_id      (in_frame_id),
    .in_frame_payload (in_frame_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_id           (out_id),
    .out_payload      (out_payload),
    .out_result_status(out_result_status),
    .out_last_of_run  (out_last_of_run),
    .frames_due       (frames_due),
    .mismatches       (mismatches)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < out_idle_pct);
  end

  // long receiver hold-off: the result holds on the output and the block stalls its input
  initial begin : receiver_hold
    @(posedge clk);
    while (!hold_go) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_frame(input logic [31:0] id, input logic [31:0] payload);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_id <= id;
    in_frame_payload <= payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_start(input logic [31:0] first);
    wait_drained(4);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= first;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cursor = first;
  endtask

  // off-sequence request: duplicate, late, far ahead (beyond or at the window edge) or fully random id
  task automatic send_stray(input logic [31:0] dup_id, input int span);
    logic [31:0] id;
    case ($urandom_range(3))
      0: id = dup_id;
      1: id = cursor - (($urandom_range(1) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 32'h7FFF_FFFF));
      2: id = cursor + span + 15 + (($urandom_range(1) == 0) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 32'h3FFF_FFFF));
      default: id = $urandom;
    endcase
    send_frame(id, $urandom);
  endtask

  // up to one window's worth of consecutive ids in some order, with strays mixed in
  task automatic send_run();
    logic [31:0] order[WINDOW_DEPTH];
    logic [31:0] swap;
    int          span;
    int          mode;
    int          j;
    span = $urandom_range(1, WINDOW_DEPTH);
    mode = $urandom_range(3);
    for (int i = 0; i < span; i++) begin
      order[i] = (mode == 1) ? cursor + span - 1 - i : cursor + i;
    end
    if (mode >= 2) begin
      for (int i = span - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        swap = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
    end
    for (int i = 0; i < span; i++) begin
      send_frame(order[i], $urandom);
      if ($urandom_range(99) < 12) send_stray(order[$urandom_range(0, i)], span);
    end
    cursor = cursor + span;
  endtask

  initial begin : stimulus
    logic [31:0] s;
    logic [31:0] first;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_frame_id = '0;
    in_frame_payload = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    hold_go = 1'b0;
    cycle_count = 0;
    frames_sent = 0;
    in_idle_pct = 9;
    out_idle_pct = 49;
    cursor = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: window edges, drops, drain across the id wrap
    s = 32'hFFFF_FFF8;
    load_start(s);
    send_frame(s + 1, 32'h0000_0000);
    send_frame(s + 1, 32'hFFFF_FFFF);       // duplicate of a parked frame
    send_frame(s + 15, 32'h1234_5678);      // last slot of the window
    send_frame(s + 16, 32'hFFFF_FFFF);      // first id beyond the window
    send_frame(s - 1, 32'h0000_0000);       // just behind
    send_frame(s + 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    send_frame(s + 32'h8000_0000, 32'h5A5A_5A5A);
    send_frame(s, 32'hFFFF_FFFF);           // releases s and s+1
    send_frame(s, 32'h0000_0001);           // already released
    send_frame(s + 2, 32'h0F0F_0F0F);
    for (int i = 4; i <= 14; i++) send_frame(s + i, $urandom);
    send_frame(s + 3, 32'hF0F0_F0F0);       // drains s+3 .. s+15 through zero

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin in_idle_pct = 9;  out_idle_pct = 49; first = 32'h0000_0000; end
        1: begin in_idle_pct = 49; out_idle_pct = 9;  first = $urandom;      end
        default: begin in_idle_pct = 0; out_idle_pct = 0; first = 32'hFFFF_FFFF; end
      endcase
      load_start(first);
      while (frames_sent < 22 + PHASE_ITEMS * (phase + 1)) begin
        if (phase == 2 && frames_sent > 22 + PHASE_ITEMS * 2 + 40) hold_go = 1'b1;
        send_run();
      end
    end

    wait_drained(40);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
